// ===== hw/rtl/bpfa_pkg.sv =====
// Shared types, codes and constants of the bitmap page frame allocator.
package bpfa_pkg;

  // Default sizing
  localparam int DEF_MAX_PAGES = 4096;
  localparam int DEF_REGIONS   = 2;

  // Address layout: 4 KiB pages, 32 pages to a bitmap word
  localparam int ADDR_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int PFN_W      = ADDR_W - PAGE_SHIFT;
  localparam int WORD_BITS  = 32;
  localparam int BIT_IDX_W  = 5;

  // Configuration port
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int PAGES_REG_W  = 13;
  localparam int CFG_REGIONS  = 2;
  localparam logic CFG_FIELD_BASE  = 1'b0;
  localparam logic CFG_FIELD_PAGES = 1'b1;

  // Operation codes
  localparam logic [1:0] OP_ALLOC     = 2'd0;
  localparam logic [1:0] OP_SET_PAGE  = 2'd1;
  localparam logic [1:0] OP_SET_RANGE = 2'd2;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Request word
  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] end_address;
    logic              mark_used;
  } bpfa_req_t;

  // Response word
  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] page_address;
  } bpfa_rsp_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AL_READ,
    ST_AL_CHECK,
    ST_SP_MATCH,
    ST_PG_READ,
    ST_PG_WRITE,
    ST_RG_START,
    ST_RG_READ,
    ST_RG_PAGE,
    ST_RG_WRITE,
    ST_DONE
  } bpfa_state_t;

endpackage

// ===== hw/rtl/bitmap_page_frame_allocator.sv =====
// Top level of the bitmap page frame allocator: region registers and sequencer.
//
//  channel  dir  handshake              word
//  req      in   req_valid / req_stall  bpfa_req_t (operation, address, end_address, mark_used)
//  rsp      out  rsp_valid / rsp_stall  bpfa_rsp_t (status, page_address)
//  cfg      in   cfg_we                 cfg_index selects register, cfg_data
//
// After reset a clear pass writes REGIONS*ceil(MAX_PAGES/32) bitmap words, one per
// cycle (256 by default), with req_stall high; cfg writes are taken meanwhile.
// Allocate: each bitmap word scanned is read and then checked; spent regions are stepped past.
// Set page: regions are compared in turn, then the word is read and written.
// Set range: per region a start step, per word a read and a write, per page a check of earlier regions.
// One bitmap port and one match unit serve all of these; a stalled rsp waits in its register.
module bitmap_page_frame_allocator
  import bpfa_pkg::*;
#(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int REGIONS   = DEF_REGIONS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  bpfa_req_t              req,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output bpfa_rsp_t              rsp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW = $clog2(MAX_PAGES + 1);
  localparam int CW = PW > PAGES_REG_W ? PW : PAGES_REG_W;

  logic [REGIONS-1:0][ADDR_W-1:0]      base;
  logic [REGIONS-1:0][PAGES_REG_W-1:0] pages_raw;
  logic [REGIONS-1:0][PW-1:0]          pages;

  // Region registers; only the first regions have register slots
  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      pages_raw <= '0;
    end else if (cfg_we) begin
      for (int r = 0; r < REGIONS; r++) begin
        if (r < CFG_REGIONS && 32'(cfg_index >> 1) == r) begin
          if (cfg_index[0] == CFG_FIELD_BASE) begin
            base[r] <= cfg_data[ADDR_W-1:0];
          end else begin
            pages_raw[r] <= cfg_data[PAGES_REG_W-1:0];
          end
        end
      end
    end
  end

  // Oversized regions clamp to MAX_PAGES
  always_comb begin
    for (int r = 0; r < REGIONS; r++) begin
      if (CW'(pages_raw[r]) > CW'(MAX_PAGES)) pages[r] = PW'(MAX_PAGES);
      else pages[r] = PW'(pages_raw[r]);
    end
  end

  bpfa_seq #(
    .MAX_PAGES (MAX_PAGES),
    .REGIONS   (REGIONS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .base      (base),
    .pages     (pages)
  );

endmodule

// ===== hw/rtl/bpfa_bitmap_ram.sv =====
// Single-port bitmap memory with registered read data.
module bpfa_bitmap_ram
  import bpfa_pkg::*;
#(
  parameter int DEPTH = DEF_REGIONS * ((DEF_MAX_PAGES + 31) / 32)
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WORD_BITS-1:0]                  wdata,
  output logic [WORD_BITS-1:0]                  rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  // Write, or read into the output register; data holds between reads
  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== hw/rtl/bpfa_match.sv =====
// Shared region match unit: offset from region base and page bound compare.
module bpfa_match
  import bpfa_pkg::*;
#(
  parameter int MAX_PAGES = DEF_MAX_PAGES
) (
  input  logic [ADDR_W-1:0]                 addr,
  input  logic [ADDR_W-1:0]                 base,
  input  logic [$clog2(MAX_PAGES+1)-1:0]    pages,
  output logic                              hit,
  output logic [$clog2(MAX_PAGES+1)-1:0]    page
);

  localparam int PW = $clog2(MAX_PAGES + 1);

  logic [ADDR_W-1:0] diff;

  // Offset modulo 2^32; below pages*4K exactly when its page number is below pages
  always_comb begin
    diff = addr - base;
    hit  = diff[ADDR_W-1:PAGE_SHIFT] < PFN_W'(pages);
    page = PW'(diff[ADDR_W-1:PAGE_SHIFT]);
  end

endmodule

// ===== hw/rtl/bpfa_seq.sv =====
// Allocator sequencer: operation control, bitmap access and response register.
module bpfa_seq
  import bpfa_pkg::*;
#(
  parameter int MAX_PAGES = DEF_MAX_PAGES,
  parameter int REGIONS   = DEF_REGIONS
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          req_valid,
  output logic                                          req_stall,
  input  bpfa_req_t                                     req,
  output logic                                          rsp_valid,
  input  logic                                          rsp_stall,
  output bpfa_rsp_t                                     rsp,
  input  logic [REGIONS-1:0][ADDR_W-1:0]                base,
  input  logic [REGIONS-1:0][$clog2(MAX_PAGES+1)-1:0]   pages
);

  localparam int WPR   = (MAX_PAGES + 31) / 32;
  localparam int DEPTH = REGIONS * WPR;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int RW    = REGIONS > 1 ? $clog2(REGIONS) : 1;
  localparam int WCW   = $clog2(WPR + 1);
  localparam int PW    = $clog2(MAX_PAGES + 1);
  localparam int PIW   = WCW + BIT_IDX_W;
  localparam logic [AW-1:0] WPR_A = AW'(WPR);
  localparam logic [WORD_BITS-1:0] MSB_MASK = {1'b1, {(WORD_BITS-1){1'b0}}};

  bpfa_state_t state, state_next;

  // Item registers
  bpfa_req_t            cur;
  logic [RW-1:0]        rgn;
  logic [RW-1:0]        q;
  logic [WCW-1:0]       wrd;
  logic [BIT_IDX_W-1:0] bitpos;
  logic [PFN_W-1:0]     acur;
  logic [WORD_BITS-1:0] mask;
  logic                 rg_end;
  logic [AW-1:0]        clr_addr;
  logic                 res_status;
  logic [ADDR_W-1:0]    res_addr;

  // RAM port
  logic                 ram_en;
  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  // Match unit port
  logic [ADDR_W-1:0]    m_addr;
  logic [ADDR_W-1:0]    m_base;
  logic [PW-1:0]        m_pages;
  logic                 m_hit;
  logic [PW-1:0]        m_page;

  // Conditions
  logic                 accept;
  logic                 slot_free;
  logic                 clr_last;
  logic                 rgn_last;
  logic [ADDR_W-1:0]    base_r;
  logic [PW-1:0]        pages_r;
  logic                 word_left;
  logic                 word_full;
  logic [BIT_IDX_W-1:0] fz;
  logic [PIW-1:0]       page_idx;
  logic                 page_last;
  logic                 q_final;
  logic                 step_page;
  logic                 in_bounds;
  logic [ADDR_W-1:0]    acur_addr;
  logic                 unaligned;

  bpfa_bitmap_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bpfa_match #(
    .MAX_PAGES (MAX_PAGES)
  ) u_match (
    .addr  (m_addr),
    .base  (m_base),
    .pages (m_pages),
    .hit   (m_hit),
    .page  (m_page)
  );

  // Shared conditions
  always_comb begin
    accept    = req_valid && !req_stall;
    slot_free = !rsp_valid || !rsp_stall;
    clr_last  = clr_addr == AW'(DEPTH - 1);
    rgn_last  = rgn == RW'(REGIONS - 1);
    base_r    = base[rgn];
    pages_r   = pages[rgn];
    word_left = PIW'(wrd) < PIW'(pages_r >> BIT_IDX_W);
    word_full = ram_rdata == '1;
    unaligned = req.address[PAGE_SHIFT-1:0] != '0;
    page_idx  = {wrd, bitpos};
    page_last = (page_idx + PIW'(1)) >= PIW'(pages_r);
    q_final   = q == rgn;
    acur_addr = {acur, {PAGE_SHIFT{1'b0}}};
    in_bounds = acur_addr >= cur.address && acur_addr <= cur.end_address;
    step_page = q_final || m_hit;
  end

  // First free page of the word, MSB first
  always_comb begin
    fz = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!ram_rdata[i]) begin
        fz = BIT_IDX_W'(WORD_BITS - 1 - i);
      end
    end
  end

  // Match unit operands: item address against region rgn, or range page against q
  always_comb begin
    if (state == ST_SP_MATCH) begin
      m_addr  = cur.address;
      m_base  = base[rgn];
      m_pages = pages[rgn];
    end else begin
      m_addr  = acur_addr;
      m_base  = base[q];
      m_pages = pages[q];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          case (req.operation)
            OP_ALLOC:     state_next = ST_AL_READ;
            OP_SET_PAGE:  state_next = unaligned ? ST_DONE : ST_SP_MATCH;
            OP_SET_RANGE: begin
              if (req.address > req.end_address || unaligned) state_next = ST_DONE;
              else state_next = ST_RG_START;
            end
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_AL_READ: begin
        if (word_left) state_next = ST_AL_CHECK;
        else if (rgn_last) state_next = ST_DONE;
      end
      ST_AL_CHECK: begin
        state_next = word_full ? ST_AL_READ : ST_DONE;
      end
      ST_SP_MATCH: begin
        if (m_hit) state_next = ST_PG_READ;
        else if (rgn_last) state_next = ST_DONE;
      end
      ST_PG_READ:  state_next = ST_PG_WRITE;
      ST_PG_WRITE: state_next = ST_DONE;
      ST_RG_START: begin
        if (pages_r != '0) state_next = ST_RG_READ;
        else if (rgn_last) state_next = ST_DONE;
      end
      ST_RG_READ: state_next = ST_RG_PAGE;
      ST_RG_PAGE: begin
        if (step_page && (bitpos == '1 || page_last)) state_next = ST_RG_WRITE;
      end
      ST_RG_WRITE: begin
        if (!rg_end) state_next = ST_RG_READ;
        else if (rgn_last) state_next = ST_DONE;
        else state_next = ST_RG_START;
      end
      ST_DONE: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs: handshake and bitmap port
  always_comb begin
    req_stall = 1'b1;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = AW'(rgn) * WPR_A + AW'(wrd);
    ram_wdata = ram_rdata;
    unique case (state) inside
      ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      ST_IDLE: req_stall = 1'b0;
      ST_AL_READ: ram_en = word_left;
      ST_AL_CHECK: begin
        ram_en    = !word_full;
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | (MSB_MASK >> fz);
      end
      ST_PG_READ, ST_RG_READ: ram_en = 1'b1;
      ST_PG_WRITE: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = cur.mark_used ? (ram_rdata | (MSB_MASK >> bitpos))
                                  : (ram_rdata & ~(MSB_MASK >> bitpos));
      end
      ST_RG_WRITE: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = (ram_rdata & ~mask) | (cur.mark_used ? mask : '0);
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clear pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR && !clr_last) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cur      <= req;
          rgn      <= '0;
          wrd      <= '0;
          res_addr <= '0;
          if (req.operation == OP_SET_RANGE && req.address <= req.end_address) begin
            res_status <= STATUS_OK;
          end else begin
            res_status <= STATUS_FAIL;
          end
        end
      end
      ST_AL_READ: begin
        if (!word_left && !rgn_last) begin
          rgn <= rgn + RW'(1);
          wrd <= '0;
        end
      end
      ST_AL_CHECK: begin
        if (!word_full) begin
          res_status <= STATUS_OK;
          res_addr   <= base_r + (ADDR_W'({wrd, fz}) << PAGE_SHIFT);
        end else begin
          wrd <= wrd + WCW'(1);
        end
      end
      ST_SP_MATCH: begin
        if (m_hit) begin
          res_status <= STATUS_OK;
          wrd        <= WCW'(m_page >> BIT_IDX_W);
          bitpos     <= m_page[BIT_IDX_W-1:0];
        end else if (!rgn_last) begin
          rgn <= rgn + RW'(1);
        end
      end
      ST_RG_START: begin
        bitpos <= '0;
        acur   <= base_r[ADDR_W-1:PAGE_SHIFT] + PFN_W'(base_r[PAGE_SHIFT-1:0] != '0);
        if (pages_r == '0 && !rgn_last) begin
          rgn <= rgn + RW'(1);
        end
      end
      ST_RG_READ: begin
        mask <= '0;
        q    <= '0;
      end
      ST_RG_PAGE: begin
        if (q_final && in_bounds) begin
          mask <= mask | (MSB_MASK >> bitpos);
        end
        if (step_page) begin
          acur   <= acur + PFN_W'(1);
          bitpos <= bitpos + BIT_IDX_W'(1);
          q      <= '0;
          rg_end <= page_last;
        end else begin
          q <= q + RW'(1);
        end
      end
      ST_RG_WRITE: begin
        if (!rg_end) begin
          wrd <= wrd + WCW'(1);
        end else if (!rgn_last) begin
          rgn <= rgn + RW'(1);
          wrd <= '0;
        end
      end
      default: ;
    endcase
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && slot_free) begin
      rsp.status       <= res_status;
      rsp.page_address <= res_addr;
    end
  end

`ifndef NO_ASSERTIONS
  // Bitmap accesses stay inside the memory
  a_ram_range: assert property (@(posedge clk) disable iff (rst)
    ram_en |-> 32'(ram_addr) < DEPTH)
    else $error("bitmap address out of range");

  // Overlap scan only looks at earlier regions and the current one
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RG_PAGE |-> q <= rgn)
    else $error("overlap scan passed current region");

  // Only a successful allocation returns an address
  a_addr_alloc: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && slot_free && res_addr != '0
      |-> cur.operation == OP_ALLOC && res_status == STATUS_OK)
    else $error("page address on non-allocation result");

  // No item is taken during the clear pass
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |=> $past(req_stall))
    else $error("item accepted during clear pass");
`endif

endmodule
